FILE: hdl/ghash_pkg.sv
// shared types and constants of the ghash accumulator
package ghash_pkg;

    localparam int unsigned BLOCK_BITS = 128;
    localparam int unsigned CNT_W      = 7;

    // reduction polynomial in gcm bit order: 0xE1 followed by 120 zeros
    localparam logic [BLOCK_BITS-1:0] GH_REDUCE = {8'hE1, 120'd0};

    localparam logic [1:0] CMD_ABSORB   = 2'd0;
    localparam logic [1:0] CMD_PAD      = 2'd1;
    localparam logic [1:0] CMD_FINALIZE = 2'd2;
    localparam logic [1:0] CMD_RESTART  = 2'd3;

    localparam logic [3:0] ADDR_H_HIGH = 4'd0;
    localparam logic [3:0] ADDR_H_LOW  = 4'd8;

    typedef logic [BLOCK_BITS-1:0] block_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gm_stat_t;

endpackage

FILE: hdl/ghash_mul.sv
// bit-serial gf(2^128) multiplier, one bit of x per cycle, msb first
module ghash_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ghash_pkg::block_t x,
    input  ghash_pkg::block_t h,
    output ghash_pkg::gm_stat_t stat,
    output ghash_pkg::block_t z
);

    ghash_pkg::block_t x_reg;
    ghash_pkg::block_t v_reg;
    ghash_pkg::block_t z_reg;
    ghash_pkg::block_t v_next;
    ghash_pkg::block_t z_next;
    logic [ghash_pkg::CNT_W-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;

    always_comb
    begin
        z_next = x_reg[ghash_pkg::BLOCK_BITS-1] ? (z_reg ^ v_reg) : z_reg;
        v_next = {1'b0, v_reg[ghash_pkg::BLOCK_BITS-1:1]}
                 ^ (v_reg[0] ? ghash_pkg::GH_REDUCE : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + {{(ghash_pkg::CNT_W-1){1'b0}}, 1'b1};
                if (cnt_reg == '1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            v_reg <= h;
            z_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[ghash_pkg::BLOCK_BITS-2:0], 1'b0};
            v_reg <= v_next;
            z_reg <= z_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign z         = z_reg;

endmodule

FILE: hdl/ghash_accumulator.sv
// ghash accumulator top level: byte stream in, 128-bit tag out
// usage notes
//   input stream s_*: one item per byte command (absorb, pad, finalize, restart)
//   output stream m_*: one item with the 128-bit tag for each finalize
//   apb port: hash key h_high at byte address 0, h_low at byte address 8
// timing
//   absorb of bytes 1..15 of a block and restart never run the multiplier
//   the 16th byte, or pad / finalize on a partial block, runs the bit-serial
//   gf(2^128) multiplier and waits for its done handshake, taking one
//   bit of the accumulator per cycle, and s_tready stays low meanwhile
//   finalize goes from the multiply (or from acceptance when the block is empty)
//   to the emit state, which loads the tag into the output register
// reset
//   accumulator, byte position and key clear to zero, no tag pending
// stall
//   a pending tag is held in the output register while m_tready is low;
//   absorb/pad/restart items are still taken, a new finalize is taken too
//   but then holds s_tready low until the pending tag leaves
module ghash_accumulator
(
    input  logic         clk,
    input  logic         rst_n,
    // s_tdata: [1:0] command, [9:2] data_byte, rest zero
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,
    // m_tdata: [63:0] tag_high, [127:64] tag_low
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    ghash_pkg::block_t acc_reg, acc_next, acc_ins;
    logic [3:0]        pos_reg, pos_next;
    logic              emit_reg, emit_next;
    logic              out_valid_reg, out_valid_next;
    logic [127:0]      out_data_reg, out_data_next;
    logic [63:0]       h_high_reg, h_low_reg;
    logic              mul_start;
    ghash_pkg::gm_stat_t mul_stat;
    ghash_pkg::block_t mul_z;
    logic [1:0]        command;
    logic [7:0]        data_byte;
    logic [6:0]        byte_base;
    logic              s_fire;

    assign command   = s_tdata[1:0];
    assign data_byte = s_tdata[9:2];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign pready    = 1'b1;
    assign prdata    = paddr[3] ? h_low_reg : h_high_reg;

    // byte 0 sits in bits 127:120
    assign byte_base = {~pos_reg, 3'b111};

    always_comb
    begin
        acc_ins = acc_reg;
        acc_ins[byte_base -: 8] = acc_reg[byte_base -: 8] ^ data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_high_reg <= '0;
            h_low_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3])
            begin
                h_low_reg <= pwdata;
            end
            else
            begin
                h_high_reg <= pwdata;
            end
        end
    end

    ghash_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (acc_next),
        .h     ({h_high_reg, h_low_reg}),
        .stat  (mul_stat),
        .z     (mul_z)
    );

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        emit_next      = emit_reg;
        mul_start      = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    unique case (command)
                        ghash_pkg::CMD_ABSORB:
                        begin
                            acc_next = acc_ins;
                            pos_next = pos_reg + 4'd1;
                            if (pos_reg == 4'd15)
                            begin
                                mul_start  = 1'b1;
                                emit_next  = 1'b0;
                                state_next = ST_MUL;
                            end
                        end
                        ghash_pkg::CMD_PAD:
                        begin
                            if (pos_reg != 4'd0)
                            begin
                                mul_start  = 1'b1;
                                emit_next  = 1'b0;
                                state_next = ST_MUL;
                            end
                        end
                        ghash_pkg::CMD_FINALIZE:
                        begin
                            emit_next = 1'b1;
                            if (pos_reg != 4'd0)
                            begin
                                mul_start  = 1'b1;
                                state_next = ST_MUL;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        ghash_pkg::CMD_RESTART:
                        begin
                            acc_next = '0;
                            pos_next = 4'd0;
                        end
                        default:
                        begin
                            acc_next = acc_reg;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    acc_next   = mul_z;
                    pos_next   = 4'd0;
                    state_next = emit_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    // tag_high in the low half, tag_low in the high half
                    out_data_next  = {acc_reg[63:0], acc_reg[127:64]};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            pos_reg       <= 4'd0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (mul_stat.busy || mul_stat.done))
        else $error("multiply state without active multiplier");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !mul_stat.busy)
        else $error("input taken while multiplier busy");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && command == ghash_pkg::CMD_RESTART) |=> (acc_reg == '0 && pos_reg == 4'd0))
        else $error("restart did not clear the accumulator");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |=> !mul_stat.done)
        else $error("multiplier done held longer than one cycle");

endmodule

FILE: tb/sv/tb_ghash_accumulator.sv
// self-checking testbench of the ghash accumulator: byte stream in, tag out, key over apb
module tb_ghash_accumulator;

    localparam int LIMIT      = 1000000;
    localparam int DRAIN_WAIT = 300;
    localparam int LONG_STALL = 400;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       hold;
    } byte_cmd_t;

    typedef struct packed {
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } tag_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [3:0]   paddr    = '0;
    logic [63:0]  pwdata   = '0;
    logic [63:0]  prdata;
    logic         pready;

    byte_cmd_t cmd_q[$];
    tag_t      tag_q[$];

    // model of the block
    ghash_pkg::block_t key_model = '0;
    ghash_pkg::block_t acc_model = '0;
    logic [3:0]        pos_model = '0;

    byte_cmd_t cur_item;
    int        send_gap     = 0;
    int        recv_gap     = 0;
    int        stall_left   = 0;
    int        stall_req    = 0;
    int        stall_seen   = 0;
    bit        quiet        = 1'b0;
    int        errors       = 0;
    int        items_sent   = 0;
    int        items_queued = 0;
    int        tags_seen    = 0;
    int        key_writes   = 0;
    int        cycles       = 0;

    ghash_accumulator i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // gf(2^128) product in gcm bit order, msb of byte 0 first
    function automatic ghash_pkg::block_t gcm_product(input ghash_pkg::block_t x,
                                                      input ghash_pkg::block_t y);
        ghash_pkg::block_t z;
        ghash_pkg::block_t v;
        z = '0;
        v = y;
        for (int i = 0; i < ghash_pkg::BLOCK_BITS; i++)
        begin
            if (x[ghash_pkg::BLOCK_BITS-1-i])
                z = z ^ v;
            v = v[0] ? ((v >> 1) ^ ghash_pkg::GH_REDUCE) : (v >> 1);
        end
        return z;
    endfunction

    task automatic advance_hash(input logic [1:0] cmd, input logic [7:0] data);
        tag_t t;
        case (cmd)
            ghash_pkg::CMD_ABSORB:
            begin
                acc_model[ghash_pkg::BLOCK_BITS-1-8*pos_model -: 8] =
                    acc_model[ghash_pkg::BLOCK_BITS-1-8*pos_model -: 8] ^ data;
                if (pos_model == 4'd15)
                begin
                    acc_model = gcm_product(acc_model, key_model);
                    pos_model = '0;
                end
                else
                    pos_model = pos_model + 4'd1;
            end
            ghash_pkg::CMD_PAD, ghash_pkg::CMD_FINALIZE:
            begin
                if (pos_model != 4'd0)
                begin
                    acc_model = gcm_product(acc_model, key_model);
                    pos_model = '0;
                end
                if (cmd == ghash_pkg::CMD_FINALIZE)
                begin
                    t.tag_high = acc_model[127:64];
                    t.tag_low  = acc_model[63:0];
                    tag_q.push_back(t);
                end
            end
            default:
            begin
                acc_model = '0;
                pos_model = '0;
            end
        endcase
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_hash(cur_item.cmd, cur_item.data);
                items_sent++;
                send_gap = quiet ? 0 : $urandom_range(0, 9);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_q.size() != 0 && !(cmd_q[0].hold && tag_q.size() != 0))
                begin
                    cur_item = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, cur_item.data, cur_item.cmd};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                recv_gap = quiet ? 0 : $urandom_range(0, 9);
            if (stall_seen != stall_req)
            begin
                stall_seen = stall_req;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // tag checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tag_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected tag: expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                tag_t exp_tag;
                exp_tag = tag_q.pop_front();
                tags_seen++;
                if (m_tdata[63:0] !== exp_tag.tag_high)
                begin
                    errors++;
                    $display("%0t tag_high mismatch: expected %h, actual %h",
                             $time, exp_tag.tag_high, m_tdata[63:0]);
                end
                if (m_tdata[127:64] !== exp_tag.tag_low)
                begin
                    errors++;
                    $display("%0t tag_low mismatch: expected %h, actual %h",
                             $time, exp_tag.tag_low, m_tdata[127:64]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] cmd, input logic [7:0] data,
                            input logic hold = 1'b0);
        byte_cmd_t it;
        it.cmd  = cmd;
        it.data = data;
        it.hold = hold;
        cmd_q.push_back(it);
        items_queued++;
    endtask

    // optional restart, a run of bytes with the odd pad, then finalize, sometimes twice
    task automatic add_message(input int max_len);
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(0, max_len);
        if ($urandom_range(0, 2) == 0)
            add_item(ghash_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
        for (int k = 0; k < len; k++)
        begin
            add_item(ghash_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 11) == 0)
                add_item(ghash_pkg::CMD_PAD, 8'($urandom_range(0, 255)));
        end
        add_item(ghash_pkg::CMD_FINALIZE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0)
            add_item(ghash_pkg::CMD_FINALIZE, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain;
        while (cmd_q.size() != 0 || s_tvalid || tag_q.size() != 0)
            @(posedge clk);
        // a pad or a 16th byte may still be multiplying
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic reg_write(input logic [3:0] addr, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ghash_pkg::ADDR_H_HIGH)
            key_model[127:64] = value;
        else
            key_model[63:0] = value;
        key_writes++;
    endtask

    initial
    begin
        ghash_pkg::block_t key;
        int                phase_start;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero key straight out of reset
        add_item(ghash_pkg::CMD_ABSORB, 8'hFF);
        add_item(ghash_pkg::CMD_FINALIZE, 8'h00);
        drain();

        reg_write(ghash_pkg::ADDR_H_HIGH, 64'h66E94BD4EF8A2C3B);
        reg_write(ghash_pkg::ADDR_H_LOW, 64'h884CFA59CA342B2E);
        add_item(ghash_pkg::CMD_FINALIZE, 8'h00);     // empty block
        add_item(ghash_pkg::CMD_PAD, 8'h55);          // pad at block boundary
        add_item(ghash_pkg::CMD_ABSORB, 8'hFF);
        add_item(ghash_pkg::CMD_ABSORB, 8'h00);
        add_item(ghash_pkg::CMD_PAD, 8'hAA);          // pad on a partial block
        add_item(ghash_pkg::CMD_FINALIZE, 8'hFF);
        add_item(ghash_pkg::CMD_FINALIZE, 8'h0F);     // repeated finalize
        add_item(ghash_pkg::CMD_RESTART, 8'hFF);
        for (int k = 0; k < 16; k++)
            add_item(ghash_pkg::CMD_ABSORB, 8'(k * 17));
        add_item(ghash_pkg::CMD_FINALIZE, 8'h00);
        drain();

        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: key = '1;
                1: key = {64'h8000_0000_0000_0000, 64'd0};   // field identity
                2: key = {64'd0, 64'd1};
                default: key = {$urandom, $urandom, $urandom, $urandom};
            endcase
            if (phase != 5)
                reg_write(ghash_pkg::ADDR_H_HIGH, key[127:64]);
            reg_write(ghash_pkg::ADDR_H_LOW, key[63:0]);
            quiet = (phase == 3);
            phase_start = items_queued;
            if (phase == 4)
            begin
                // receiver holds off while finalizes keep coming
                stall_req++;
                for (int k = 0; k < 20; k++)
                begin
                    add_item(ghash_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)));
                    add_item(ghash_pkg::CMD_FINALIZE, 8'($urandom_range(0, 255)));
                end
            end
            while (items_queued - phase_start < 80)
            begin
                if ($urandom_range(0, 7) == 0)
                    add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                else
                    add_message(20);
                if (phase == 6 && items_queued - phase_start > 40 &&
                    items_queued - phase_start < 60)
                    add_item(ghash_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)), 1'b1);
            end
            drain();
        end

        $display("covered %0d items and %0d tags under %0d key writes", items_sent, tags_seen,
                 key_writes);
        $display("all commands, partial and full blocks, long output stall, input pauses");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
